// ----- rtl/core/lsoc_pkg.sv -----
// Shared types and constants for the LIFO stack with occurrence count.
// Holds the request and response item layouts and the internal control structs.
// No dependencies.
package lsoc_pkg;

	// Stack geometry
	localparam int unsigned DEPTH = 128;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned LVL_W = $clog2(DEPTH + 1);

	// Item field widths
	localparam int unsigned OP_W   = 3;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned STS_W  = 2;
	localparam int unsigned CNT_W  = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_OVERFLOW  = 2'd1;
	localparam logic [STS_W-1:0] STS_UNDERFLOW = 2'd2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LVL_W-1:0]  level_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0]         status;
		logic signed [WORD_W-1:0] data;
		logic [CNT_W-1:0]         match_count;
		logic [CNT_W-1:0]         occupancy;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	// Store port request: one write and one read address per cycle
	typedef struct packed {
		logic  wr_en;
		idx_t  wr_addr;
		word_t wr_data;
		logic  rd_en;
		idx_t  rd_addr;
	} store_req_t;

	// Match unit control: start clears the tally, probe marks a read issued this cycle
	typedef struct packed {
		logic start;
		logic probe;
	} match_ctl_t;

endpackage

// ----- rtl/core/lifo_stack_with_occurrence_count.sv -----
// LIFO stack of DEPTH (128) signed 32-bit words with an occurrence counter.
// Each request item pushes, pops, peeks, counts matches of a word, or clears;
// one response item follows every request. Push, clear and unused codes give
// their response in the cycle after acceptance, so with the response taken at
// once they run one item per cycle. Pop and peek answer from S_READ, because
// the word comes from the store's registered read port. Count answers from
// S_DRAIN after S_WALK: a sequencer reads the entries one per cycle through
// that single read port and a shared comparator tallies the hits. Errors
// (overflow, underflow) answer in the cycle after acceptance. A new request
// is taken only when the sequencer is idle and the response register is free
// or being drained. The store needs no clearing pass after reset.
// Depends on lsoc_pkg, lsoc_store and lsoc_match.
module lifo_stack_with_occurrence_count (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lsoc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lsoc_pkg::rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WALK,
		S_DRAIN
	} state_t;

	localparam lsoc_pkg::level_t FULL_LVL = lsoc_pkg::level_t'(lsoc_pkg::DEPTH);

	state_t                state_q;
	lsoc_pkg::level_t      fill_q;
	lsoc_pkg::level_t      cnt_q;
	lsoc_pkg::word_t       key_q;
	lsoc_pkg::rsp_t        rsp_q;
	logic                  rsp_valid_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  rsp_load;
	lsoc_pkg::level_t      fill_dec;
	lsoc_pkg::level_t      fill_inc;
	lsoc_pkg::store_req_t  store_req;
	lsoc_pkg::word_t       rd_data;
	lsoc_pkg::match_ctl_t  match_ctl;
	lsoc_pkg::level_t      next_count;

	// Build a response from status, word, tally and resulting fill level
	function automatic lsoc_pkg::rsp_t make_rsp(
		input logic [lsoc_pkg::STS_W-1:0] status,
		input lsoc_pkg::word_t            word,
		input lsoc_pkg::level_t           tally,
		input lsoc_pkg::level_t           level
	);
		lsoc_pkg::rsp_t r;
		r.status      = status;
		r.data        = $signed(word);
		r.match_count = lsoc_pkg::CNT_W'(tally);
		r.occupancy   = lsoc_pkg::CNT_W'(level);
		r.is_empty    = (level == '0);
		r.is_full     = (level == FULL_LVL);
		return r;
	endfunction

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign full      = (fill_q == FULL_LVL);
	assign empty     = (fill_q == '0);
	assign fill_dec  = fill_q - lsoc_pkg::level_t'(1);
	assign fill_inc  = fill_q + lsoc_pkg::level_t'(1);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Drive the store ports: push write, top read, or walk read
	always_comb begin
		store_req         = '0;
		store_req.wr_addr = fill_q[lsoc_pkg::IDX_W-1:0];
		store_req.wr_data = req.value;
		store_req.rd_addr = fill_dec[lsoc_pkg::IDX_W-1:0];
		match_ctl         = '0;
		if (state_q == S_IDLE && accept) begin
			case (req.operation)
				lsoc_pkg::OP_PUSH: begin
					store_req.wr_en = !full;
				end
				lsoc_pkg::OP_POP, lsoc_pkg::OP_PEEK: begin
					store_req.rd_en = !empty;
				end
				lsoc_pkg::OP_COUNT: begin
					match_ctl.start = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_WALK) begin
			store_req.rd_en   = 1'b1;
			store_req.rd_addr = cnt_q[lsoc_pkg::IDX_W-1:0];
			match_ctl.probe   = 1'b1;
		end
	end

	// Flag the cycles that load the response register
	always_comb begin
		rsp_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.operation)
						lsoc_pkg::OP_POP, lsoc_pkg::OP_PEEK, lsoc_pkg::OP_COUNT: begin
							rsp_load = empty;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			S_READ, S_DRAIN: begin
				rsp_load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	lsoc_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (rd_data)
	);

	lsoc_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (match_ctl),
		.rd_data    (rd_data),
		.key        (key_q),
		.next_count (next_count)
	);

	// Sequence each item and load the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			key_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Hold the response until taken; a load sets it again
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_ready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= req.value;
						case (req.operation)
							lsoc_pkg::OP_PUSH: begin
								if (full) begin
									rsp_q <= make_rsp(lsoc_pkg::STS_OVERFLOW, '0, '0, fill_q);
								end else begin
									fill_q <= fill_inc;
									rsp_q  <= make_rsp(lsoc_pkg::STS_OK, '0, '0, fill_inc);
								end
							end
							lsoc_pkg::OP_POP: begin
								if (empty) begin
									rsp_q <= make_rsp(lsoc_pkg::STS_UNDERFLOW, '0, '0, fill_q);
								end else begin
									fill_q  <= fill_dec;
									state_q <= S_READ;
								end
							end
							lsoc_pkg::OP_PEEK: begin
								if (empty) begin
									rsp_q <= make_rsp(lsoc_pkg::STS_UNDERFLOW, '0, '0, fill_q);
								end else begin
									state_q <= S_READ;
								end
							end
							lsoc_pkg::OP_COUNT: begin
								if (empty) begin
									rsp_q <= make_rsp(lsoc_pkg::STS_UNDERFLOW, '0, '0, fill_q);
								end else begin
									cnt_q   <= '0;
									state_q <= S_WALK;
								end
							end
							lsoc_pkg::OP_CLEAR: begin
								fill_q <= '0;
								rsp_q  <= make_rsp(lsoc_pkg::STS_OK, '0, '0, '0);
							end
							default: begin
								rsp_q <= make_rsp(lsoc_pkg::STS_OK, '0, '0, fill_q);
							end
						endcase
					end
				end
				S_READ: begin
					rsp_q   <= make_rsp(lsoc_pkg::STS_OK, rd_data, '0, fill_q);
					state_q <= S_IDLE;
				end
				S_WALK: begin
					// Advance one entry per cycle up to the top
					cnt_q <= cnt_q + lsoc_pkg::level_t'(1);
					if (cnt_q == fill_dec) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					rsp_q   <= make_rsp(lsoc_pkg::STS_OK, '0, next_count, fill_q);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/lsoc_store.sv -----
// Stack word storage: one write port and one read port with registered read data.
// Depends on lsoc_pkg.
module lsoc_store (
	input  logic                clk,
	input  lsoc_pkg::store_req_t req,
	output lsoc_pkg::word_t     rd_data
);

	lsoc_pkg::word_t mem_q [lsoc_pkg::DEPTH];

	// Write the pushed word
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

// ----- rtl/core/lsoc_match.sv -----
// Shared compare unit: compares one read word a cycle against the key and tallies hits.
// Depends on lsoc_pkg.
module lsoc_match (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsoc_pkg::match_ctl_t ctl,
	input  lsoc_pkg::word_t      rd_data,
	input  lsoc_pkg::word_t      key,
	output lsoc_pkg::level_t     next_count
);

	logic             probe_s1;
	lsoc_pkg::level_t count_q;
	logic             hit;

	// Compare the word read on the previous cycle
	assign hit        = probe_s1 && (rd_data == key);
	assign next_count = count_q + lsoc_pkg::level_t'(hit);

	// Track read data valid and accumulate hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			probe_s1 <= ctl.probe;
			if (ctl.start) begin
				count_q <= '0;
			end else begin
				count_q <= next_count;
			end
		end
	end

endmodule

// ----- tb/tb_lifo_stack_with_occurrence_count.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lifo_stack_with_occurrence_count.
// Drives push, pop, peek, count, clear and spare-code items and checks each reply
// against a stack model kept in the bench. Depends on lsoc_pkg and the top RTL.
module tb_lifo_stack_with_occurrence_count;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	lsoc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	lsoc_pkg::rsp_t rsp;

	// Idle percentages of the two channels
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned error_count = 0;
	// Items sent, and the fill level the stimulus is steering
	int unsigned items_sent = 0;
	int unsigned plan_level = 0;

	// Stack model, updated as each item is accepted
	logic signed [lsoc_pkg::WORD_W-1:0] model_words [lsoc_pkg::DEPTH];
	int unsigned model_level = 0;
	lsoc_pkg::rsp_t stack_reply_q [$];

	lifo_stack_with_occurrence_count u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one item to the stack model and return the reply it should give
	function automatic lsoc_pkg::rsp_t apply_stack_op(lsoc_pkg::req_t item);
		lsoc_pkg::rsp_t reply;
		reply = '0;
		case (item.operation)
			lsoc_pkg::OP_PUSH: begin
				if (model_level >= lsoc_pkg::DEPTH) begin
					reply.status = lsoc_pkg::STS_OVERFLOW;
				end else begin
					model_words[model_level] = item.value;
					model_level++;
				end
			end
			lsoc_pkg::OP_POP: begin
				if (model_level == 0) begin
					reply.status = lsoc_pkg::STS_UNDERFLOW;
				end else begin
					model_level--;
					reply.data = model_words[model_level];
				end
			end
			lsoc_pkg::OP_PEEK: begin
				if (model_level == 0) begin
					reply.status = lsoc_pkg::STS_UNDERFLOW;
				end else begin
					reply.data = model_words[model_level - 1];
				end
			end
			lsoc_pkg::OP_COUNT: begin
				if (model_level == 0) begin
					reply.status = lsoc_pkg::STS_UNDERFLOW;
				end else begin
					for (int i = 0; i < model_level; i++) begin
						if (model_words[i] == item.value)
							reply.match_count++;
					end
				end
			end
			lsoc_pkg::OP_CLEAR: begin
				model_level = 0;
			end
			default: begin
			end
		endcase
		reply.occupancy = lsoc_pkg::CNT_W'(model_level);
		reply.is_empty  = (model_level == 0);
		reply.is_full   = (model_level == lsoc_pkg::DEPTH);
		return reply;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		error_count++;
		$display("%0t ns: %s mismatch, got %h expected %h", $time, field, got, want);
	endtask

	// Toggle the receiver's ready at random
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Record accepted requests, compare accepted replies with the oldest prediction
	always @(posedge clk) begin
		lsoc_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				stack_reply_q.push_back(apply_stack_op(req));
			if (rsp_valid && rsp_ready) begin
				if (stack_reply_q.size() == 0) begin
					report_mismatch("unexpected reply item", rsp.data, '0);
				end else begin
					want = stack_reply_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.data !== want.data)
						report_mismatch("data", rsp.data, want.data);
					if (rsp.match_count !== want.match_count)
						report_mismatch("match_count", 32'(rsp.match_count),
							32'(want.match_count));
					if (rsp.occupancy !== want.occupancy)
						report_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
					if (rsp.is_empty !== want.is_empty)
						report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
					if (rsp.is_full !== want.is_full)
						report_mismatch("is_full", 32'(rsp.is_full), 32'(want.is_full));
				end
			end
		end
	end

	// Send one item, idling first at random, and hold it until accepted
	task automatic send_item(logic [lsoc_pkg::OP_W-1:0] op,
		logic signed [lsoc_pkg::WORD_W-1:0] word);
		lsoc_pkg::req_t item;
		item.operation = op;
		item.value     = word;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		case (op)
			lsoc_pkg::OP_PUSH:  if (plan_level < lsoc_pkg::DEPTH) plan_level++;
			lsoc_pkg::OP_POP:   if (plan_level > 0) plan_level--;
			lsoc_pkg::OP_CLEAR: plan_level = 0;
			default: begin
			end
		endcase
		items_sent++;
	endtask

	// Hold off new items until every outstanding reply has arrived
	task automatic wait_for_replies();
		req_valid <= 1'b0;
		@(posedge clk);
		while (stack_reply_q.size() != 0) @(posedge clk);
	endtask

	// Mostly words from a small pool so that counts find matches
	function automatic logic signed [lsoc_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(5))
			0: return {1'b1, {(lsoc_pkg::WORD_W-1){1'b0}}};
			1: return {1'b0, {(lsoc_pkg::WORD_W-1){1'b1}}};
			2: return '1;
			3, 4: return lsoc_pkg::WORD_W'($urandom_range(3));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [lsoc_pkg::OP_W-1:0] pick_op();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 45) return lsoc_pkg::OP_PUSH;
		if (roll < 65) return lsoc_pkg::OP_POP;
		if (roll < 75) return lsoc_pkg::OP_PEEK;
		if (roll < 95) return lsoc_pkg::OP_COUNT;
		if (roll < 97) return lsoc_pkg::OP_CLEAR;
		return lsoc_pkg::OP_W'($urandom_range(2**lsoc_pkg::OP_W - 1, lsoc_pkg::OP_CLEAR + 1));
	endfunction

	// Underflow on an empty stack, clear on empty, and the spare codes
	task automatic test_empty_stack();
		send_item(lsoc_pkg::OP_POP, '0);
		send_item(lsoc_pkg::OP_PEEK, '1);
		send_item(lsoc_pkg::OP_COUNT, '1);
		send_item(lsoc_pkg::OP_CLEAR, '0);
		for (int c = lsoc_pkg::OP_CLEAR + 1; c < 2**lsoc_pkg::OP_W; c++)
			send_item(lsoc_pkg::OP_W'(c), $urandom());
	endtask

	// Word extremes, duplicates in counts, and pop back down to empty
	task automatic test_word_extremes();
		logic signed [lsoc_pkg::WORD_W-1:0] min_word;
		logic signed [lsoc_pkg::WORD_W-1:0] max_word;
		min_word = {1'b1, {(lsoc_pkg::WORD_W-1){1'b0}}};
		max_word = {1'b0, {(lsoc_pkg::WORD_W-1){1'b1}}};
		send_item(lsoc_pkg::OP_PUSH, min_word);
		send_item(lsoc_pkg::OP_PUSH, max_word);
		send_item(lsoc_pkg::OP_PUSH, '1);
		send_item(lsoc_pkg::OP_PUSH, '0);
		send_item(lsoc_pkg::OP_PUSH, '1);
		send_item(lsoc_pkg::OP_PEEK, '0);
		send_item(lsoc_pkg::OP_COUNT, '1);
		send_item(lsoc_pkg::OP_COUNT, min_word);
		send_item(lsoc_pkg::OP_COUNT, max_word - 1);
		send_item(lsoc_pkg::OP_POP, '0);
		send_item(lsoc_pkg::OP_POP, '0);
		send_item(lsoc_pkg::OP_PEEK, '0);
		send_item(lsoc_pkg::OP_CLEAR, '1);
		send_item(lsoc_pkg::OP_PEEK, '0);
		send_item(lsoc_pkg::OP_PUSH, max_word);
		send_item(lsoc_pkg::OP_POP, '0);
		send_item(lsoc_pkg::OP_POP, '0);
	endtask

	// Random runs: short mixed bursts, fills to full, drains to empty, and noise
	task automatic test_random_traffic(int unsigned target);
		int unsigned roll;
		int unsigned burst_len;
		logic signed [lsoc_pkg::WORD_W-1:0] fill_word;
		logic same_word;
		while (items_sent < target) begin
			roll = $urandom_range(99);
			if (roll < 4) begin
				// fill to full, overflow, then count and peek
				if ($urandom_range(1))
					send_item(lsoc_pkg::OP_CLEAR, $urandom());
				fill_word = pick_word();
				same_word = 1'($urandom_range(1));
				while (plan_level < lsoc_pkg::DEPTH)
					send_item(lsoc_pkg::OP_PUSH, same_word ? fill_word : pick_word());
				repeat ($urandom_range(3, 1)) send_item(lsoc_pkg::OP_PUSH, pick_word());
				send_item(lsoc_pkg::OP_COUNT, fill_word);
				send_item(lsoc_pkg::OP_PEEK, $urandom());
			end else if (roll < 12) begin
				// drain to empty, then underflow
				while (plan_level > 0)
					send_item($urandom_range(3) == 0 ? lsoc_pkg::OP_PEEK : lsoc_pkg::OP_POP,
						$urandom());
				send_item(lsoc_pkg::OP_POP, $urandom());
				send_item($urandom_range(1) ? lsoc_pkg::OP_PEEK : lsoc_pkg::OP_COUNT,
					pick_word());
			end else if (roll < 20) begin
				send_item(lsoc_pkg::OP_W'($urandom_range(2**lsoc_pkg::OP_W - 1,
					lsoc_pkg::OP_CLEAR)), $urandom());
			end else if (roll < 22) begin
				wait_for_replies();
			end else begin
				burst_len = $urandom_range(12, 4);
				repeat (burst_len) send_item(pick_op(), pick_word());
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 70;
		test_empty_stack();
		test_word_extremes();
		test_random_traffic(310);
		wait_for_replies();

		send_idle_pct = 70;
		recv_idle_pct = 23;
		test_random_traffic(620);
		wait_for_replies();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(930);
		wait_for_replies();
		repeat (140) @(posedge clk);

		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(8_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule

// ----- lifo_stack_with_occurrence_count.f -----
rtl/core/lsoc_pkg.sv
rtl/core/lsoc_store.sv
rtl/core/lsoc_match.sv
rtl/core/lifo_stack_with_occurrence_count.sv
tb/tb_lifo_stack_with_occurrence_count.sv
